// ----- sv/wpp_pkg.sv -----
// ----------------------------------------------------------------------------
// WAV PCM16 parser package
// Shared types and constants for the WAV PCM16 stream parser.
// ----------------------------------------------------------------------------
package wpp_pkg;

  // Fixed header layout
  localparam int unsigned HEADER_BYTES = 36;
  localparam int unsigned POS_W        = $clog2(HEADER_BYTES);
  localparam int unsigned FMT_LO_POS   = 20;
  localparam int unsigned FMT_HI_POS   = 21;
  localparam int unsigned BITS_LO_POS  = 34;
  localparam int unsigned FIELD_BYTES  = 4;

  localparam logic [15:0] PCM_FORMAT = 16'd1;
  localparam logic [15:0] PCM_BITS   = 16'd16;
  localparam logic [31:0] DATA_TAG   = 32'h6461_7461;  // "data"

  // Queue between parser and output stage
  localparam int unsigned QUEUE_DEPTH = 2;

  // Output stream widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned TDATA_O_W  = SAMPLE_W + SIZE_W;
  localparam int unsigned KIND_W     = 2;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TAG,
    PH_SIZE,
    PH_SKIP,
    PH_DATA,
    PH_DONE,
    PH_FAILED
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE,
    KIND_DATA_FOUND,
    KIND_UNSUPPORTED,
    KIND_DATA_MISSING
  } kind_e;

  typedef struct packed {
    kind_e                      kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [SIZE_W-1:0]          data_size;
    logic                       last_sample;
  } event_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- sv/wpp_front.sv -----
// ----------------------------------------------------------------------------
// WAV parser front end
// Accepts file bytes, walks the header and chunk structure, and pushes one
// event per result into the queue.
// ----------------------------------------------------------------------------
module wpp_front import wpp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_file_i,
  input  queue_status_t q_status_i,
  output logic          push_o,
  output event_t        event_o
);

  phase_e             phase_q, phase_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [31:0]        tag_q, tag_d;
  logic [31:0]        len_q, len_d;
  logic [32:0]        rem_q, rem_d;
  logic [7:0]         held_q, held_d;
  logic [15:0]        fmt_q, fmt_d;

  logic               accept;
  logic [31:0]        len_next;
  logic [32:0]        rem_dec;
  logic               last_field_byte;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign len_next   = {data_byte_i, len_q[31:8]};
  assign rem_dec    = rem_q - 33'd1;
  assign last_field_byte = (pos_q >= POS_W'(FIELD_BYTES - 1));

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      held_q  <= '0;
      fmt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      held_q  <= held_d;
      fmt_q   <= fmt_d;
    end
  end

  // Advance the parse on each accepted byte
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    tag_d   = tag_q;
    len_d   = len_q;
    rem_d   = rem_q;
    held_d  = held_q;
    fmt_d   = fmt_q;
    push_o  = 1'b0;
    event_o.kind        = KIND_SAMPLE;
    event_o.sample      = '0;
    event_o.data_size   = '0;
    event_o.last_sample = 1'b0;

    if (accept) begin
      case (phase_q)
        PH_HEADER: begin
          if (pos_q == POS_W'(FMT_LO_POS)) begin
            fmt_d = {8'h00, data_byte_i};
          end else if (pos_q == POS_W'(FMT_HI_POS)) begin
            fmt_d = {data_byte_i, fmt_q[7:0]};
          end else if (pos_q == POS_W'(BITS_LO_POS)) begin
            held_d = data_byte_i;
          end
          if (pos_q == POS_W'(HEADER_BYTES - 1)) begin
            pos_d = '0;
            tag_d = '0;
            if (fmt_q != PCM_FORMAT || {data_byte_i, held_q} != PCM_BITS) begin
              push_o       = 1'b1;
              event_o.kind = KIND_UNSUPPORTED;
              phase_d      = PH_FAILED;
            end else begin
              phase_d = PH_TAG;
            end
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
        end
        PH_TAG: begin
          tag_d = {tag_q[23:0], data_byte_i};
          if (last_field_byte) begin
            pos_d   = '0;
            len_d   = '0;
            phase_d = PH_SIZE;
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
        end
        PH_SIZE: begin
          len_d = len_next;
          if (last_field_byte) begin
            pos_d = '0;
            if (tag_q == DATA_TAG) begin
              push_o            = 1'b1;
              event_o.kind      = KIND_DATA_FOUND;
              event_o.data_size = len_next;
              rem_d   = {1'b0, len_next[31:1], 1'b0};
              phase_d = (len_next[31:1] == '0) ? PH_DONE : PH_DATA;
            end else begin
              // Pad odd chunk sizes up to even
              rem_d   = {1'b0, len_next} + {32'd0, len_next[0]};
              tag_d   = '0;
              phase_d = (len_next == '0) ? PH_TAG : PH_SKIP;
            end
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
        end
        PH_SKIP: begin
          if (rem_q == '0 || rem_q == 33'd1) begin
            rem_d   = '0;
            tag_d   = '0;
            pos_d   = '0;
            phase_d = PH_TAG;
          end else begin
            rem_d = rem_dec;
          end
        end
        PH_DATA: begin
          rem_d = rem_dec;
          if (!rem_q[0]) begin
            held_d = data_byte_i;
          end else begin
            push_o              = 1'b1;
            event_o.kind        = KIND_SAMPLE;
            event_o.sample      = {data_byte_i, held_q};
            event_o.last_sample = (rem_q == 33'd1);
            if (rem_q == 33'd1) begin
              phase_d = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase

      // End of file: report a missing data chunk unless one was found or the format failed, then restart
      if (end_of_file_i) begin
        if (!push_o && (phase_d == PH_HEADER || phase_d == PH_TAG ||
                        phase_d == PH_SIZE || phase_d == PH_SKIP)) begin
          push_o       = 1'b1;
          event_o.kind = KIND_DATA_MISSING;
        end
        phase_d = PH_HEADER;
        pos_d   = '0;
        tag_d   = '0;
        len_d   = '0;
        rem_d   = '0;
        held_d  = '0;
        fmt_d   = '0;
      end
    end
  end

endmodule

// ----- sv/wpp_fifo.sv -----
// ----------------------------------------------------------------------------
// WAV parser event queue
// Short register queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
module wpp_fifo import wpp_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  event_t        data_i,
  input  logic          pop_i,
  output event_t        data_o,
  output queue_status_t status_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  event_t         mem_q [Depth];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           do_push, do_pop;

  assign status_o.full  = (count_q == CW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- sv/wpp_back.sv -----
// ----------------------------------------------------------------------------
// WAV parser output stage
// Pops events from the queue into the registered master stream.
// ----------------------------------------------------------------------------
module wpp_back import wpp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  queue_status_t        q_status_i,
  input  event_t               event_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [TDATA_O_W-1:0] m_axis_tdata_o,
  output logic [KIND_W-1:0]    m_axis_tuser_o,
  output logic                 m_axis_tlast_o
);

  logic   valid_q, valid_d;
  event_t event_q;

  // Load when the register is free or its transaction completes
  assign pop_o   = !q_status_i.empty && (!valid_q || m_axis_tready_i);
  assign valid_d = pop_o || (valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      event_q <= event_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {event_q.data_size, event_q.sample};
  assign m_axis_tuser_o  = event_q.kind;
  assign m_axis_tlast_o  = event_q.last_sample;

endmodule

// ----- sv/wav_pcm16_stream_parser.sv -----
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser
// Parses a WAV file byte stream and emits chunk reports and Q1.15 samples.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one file byte per transaction in tdata[7:0];
//   tlast marks the final byte of the file, after which parsing restarts
//   at the fixed 36-byte header.
//   Master stream carries one result per transaction: tuser is the kind
//   (sample, data chunk found, unsupported format, data chunk missing),
//   tdata holds the sample in [15:0] and the data chunk size in [47:16],
//   and tlast flags the final whole sample of the data chunk.
//   Path: a result is written into the queue by the parser state update,
//   then loaded into the output register.
//   Throughput: one byte per cycle while the queue is not full; the queue
//   drains one event per cycle while the receiver holds tready high.
//   Reset: the parser returns to the header phase, queue and output empty.
//   Stall: when the receiver holds tready low the output register holds,
//   the queue absorbs up to its depth, then s_axis_tready_o drops.
// ----------------------------------------------------------------------------
module wav_pcm16_stream_parser import wpp_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [7:0] data_byte
  input  logic                 s_axis_tlast_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [TDATA_O_W-1:0] m_axis_tdata_o,   // [15:0] sample, [47:16] data_size
  output logic [KIND_W-1:0]    m_axis_tuser_o,   // [1:0] kind
  output logic                 m_axis_tlast_o
);

  queue_status_t q_status;
  logic          q_push, q_pop;
  event_t        q_in, q_out;

  wpp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .data_byte_i   (s_axis_tdata_i),
    .end_of_file_i (s_axis_tlast_i),
    .q_status_i    (q_status),
    .push_o        (q_push),
    .event_o       (q_in)
  );

  wpp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (q_in),
    .pop_i    (q_pop),
    .data_o   (q_out),
    .status_o (q_status)
  );

  wpp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_status),
    .event_i         (q_out),
    .pop_o           (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Parser never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full)
    else $error("event pushed into full queue");

  // Queue status flags are never both set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty");

  // Last-sample flag only travels with a sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tuser_o == KIND_SAMPLE))
    else $error("tlast set on a non-sample result");

  // A popped event reaches the output register in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> m_axis_tvalid_o)
    else $error("popped event not presented");

endmodule
